@@ design/lbp_pkg.sv @@
package lbp_pkg;

  localparam int unsigned TickW = 16;
  localparam logic [TickW-1:0] TickMax = '1;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SEL   = 2'd1;
  localparam logic [1:0] CMD_STATE = 2'd2;

  localparam logic [2:0] PAT_OFF    = 3'd0;
  localparam logic [2:0] PAT_SOLID  = 3'd1;
  localparam logic [2:0] PAT_SLOW   = 3'd2;
  localparam logic [2:0] PAT_FAST   = 3'd3;
  localparam logic [2:0] PAT_DOUBLE = 3'd4;
  localparam logic [2:0] PAT_BEAT   = 3'd5;
  localparam logic [2:0] PAT_TRIPLE = 3'd6;
  localparam logic [2:0] PAT_REPAIR = 3'd7;

  localparam logic [2:0] NODE_UNCONFIGURED = 3'd0;
  localparam logic [2:0] NODE_PAIRING      = 3'd1;
  localparam logic [2:0] NODE_CONFIGURED   = 3'd2;
  localparam logic [2:0] NODE_OPERATIONAL  = 3'd3;
  localparam logic [2:0] NODE_ERROR        = 3'd4;
  localparam logic [2:0] NODE_REPAIRING    = 3'd5;

  localparam logic [2:0] REG_ACTIVE_LOW    = 3'd0;
  localparam logic [2:0] REG_SLOW_PERIOD   = 3'd1;
  localparam logic [2:0] REG_FAST_PERIOD   = 3'd2;
  localparam logic [2:0] REG_QUICK_PERIOD  = 3'd3;
  localparam logic [2:0] REG_GROUP_PAUSE   = 3'd4;
  localparam logic [2:0] REG_BEAT_INTERVAL = 3'd5;
  localparam logic [2:0] REG_BEAT_DARK     = 3'd6;
  localparam logic [2:0] REG_REPAIR_PAUSE  = 3'd7;

  localparam logic [2:0] GROUP_END_PAIR   = 3'd4;
  localparam logic [2:0] GROUP_END_TRIPLE = 3'd6;

  typedef struct packed {
    logic             active_low;
    logic [TickW-1:0] slow_period;
    logic [TickW-1:0] fast_period;
    logic [TickW-1:0] quick_period;
    logic [TickW-1:0] group_pause;
    logic [TickW-1:0] beat_interval;
    logic [TickW-1:0] beat_dark;
    logic [TickW-1:0] repair_pause;
  } lbp_cfg_t;

  typedef struct packed {
    logic             lit;
    logic [2:0]       pattern;
    logic [TickW-1:0] elapsed;
    logic [2:0]       phase;
    logic             pausing;
  } lbp_state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] pattern_sel;
    logic [2:0] node_state;
  } lbp_req_t;

endpackage

@@ design/lbp_step.sv @@
module lbp_step (
  input  lbp_pkg::lbp_cfg_t     cfg,
  input  lbp_pkg::lbp_req_t     req,
  input  lbp_pkg::lbp_state_t   cur,
  input  logic [15:0]           repair_ticks,
  output lbp_pkg::lbp_state_t   nxt
);
  import lbp_pkg::*;

  logic [TickW-1:0] elapsed_inc;
  logic [TickW-1:0] toggle_len;
  logic [TickW-1:0] step_len;
  logic [TickW-1:0] pause_len;
  logic [2:0]       group_end;
  logic [2:0]       phase_inc;
  logic [2:0]       new_pat;
  logic             do_sel;
  lbp_state_t       ticked;

  // node state to pattern, or pattern_sel for a select command
  always_comb begin
    unique case (req.node_state)
      NODE_UNCONFIGURED: new_pat = PAT_SLOW;
      NODE_PAIRING:      new_pat = PAT_FAST;
      NODE_CONFIGURED:   new_pat = PAT_DOUBLE;
      NODE_OPERATIONAL:  new_pat = PAT_BEAT;
      NODE_ERROR:        new_pat = PAT_TRIPLE;
      NODE_REPAIRING:    new_pat = PAT_REPAIR;
      default:           new_pat = PAT_OFF;
    endcase
    if (req.cmd == CMD_SEL) begin
      new_pat = req.pattern_sel;
    end
  end

  assign elapsed_inc = (cur.elapsed != TickMax) ? cur.elapsed + TickW'(1) : cur.elapsed;
  assign phase_inc   = cur.phase + 3'd1;

  always_comb begin
    toggle_len = cfg.slow_period;
    step_len   = cfg.quick_period;
    pause_len  = cfg.group_pause;
    group_end  = GROUP_END_PAIR;
    case (cur.pattern)
      PAT_FAST:   toggle_len = cfg.fast_period;
      PAT_BEAT:   toggle_len = cur.lit ? cfg.beat_interval : cfg.beat_dark;
      PAT_TRIPLE: group_end  = GROUP_END_TRIPLE;
      PAT_REPAIR: begin
        step_len  = repair_ticks;
        pause_len = cfg.repair_pause;
      end
      default: ;
    endcase
  end

  always_comb begin
    ticked = cur;
    ticked.elapsed = elapsed_inc;
    case (cur.pattern) inside
      PAT_SLOW, PAT_FAST, PAT_BEAT: begin
        if (elapsed_inc >= toggle_len) begin
          ticked.elapsed = '0;
          ticked.lit     = ~cur.lit;
        end
      end
      PAT_DOUBLE, PAT_TRIPLE, PAT_REPAIR: begin
        if (cur.pausing) begin
          if (elapsed_inc >= pause_len) begin
            ticked.elapsed = '0;
            ticked.pausing = 1'b0;
            ticked.phase   = '0;
            ticked.lit     = 1'b1;
          end
        end else if (elapsed_inc >= step_len) begin
          ticked.elapsed = '0;
          if (phase_inc >= group_end) begin
            ticked.pausing = 1'b1;
            ticked.phase   = '0;
          end else begin
            ticked.phase = phase_inc;
            ticked.lit   = ~phase_inc[0];
          end
        end
      end
      default: ;
    endcase
  end

  assign do_sel = ((req.cmd == CMD_SEL) || (req.cmd == CMD_STATE)) && (new_pat != cur.pattern);

  always_comb begin
    nxt = cur;
    if (req.cmd == CMD_TICK) begin
      nxt = ticked;
    end else if (do_sel) begin
      nxt.pattern = new_pat;
      nxt.elapsed = '0;
      nxt.phase   = '0;
      nxt.pausing = 1'b0;
      nxt.lit     = (new_pat != PAT_OFF);
    end
  end

endmodule

@@ design/led_blink_pattern_generator.sv @@
// a request accepted into the request register passes through lbp_step into the result
// register, waiting there while out_ready is low with out_valid set; throughput: one
// request per cycle unless the output stalls, the state update a single pass between the two registers
// reset: synchronous active-high rst clears the pipeline, the led state and
// returns every configuration register to its default
module led_blink_pattern_generator #(
  parameter int unsigned REPAIR_BLINK_TICKS = 150
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [2:0]  pattern_sel,
  input  logic [2:0]  node_state,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pin_level,
  output logic        led_lit,
  output logic [2:0]  pattern_now,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lbp_pkg::*;

  lbp_cfg_t   cfg;
  lbp_state_t state;
  lbp_state_t state_next;
  lbp_req_t   req;
  logic       req_valid;
  logic       advance;

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_low    <= 1'b0;
      cfg.slow_period   <= 16'd1000;
      cfg.fast_period   <= 16'd200;
      cfg.quick_period  <= 16'd150;
      cfg.group_pause   <= 16'd1000;
      cfg.beat_interval <= 16'd5000;
      cfg.beat_dark     <= 16'd100;
      cfg.repair_pause  <= 16'd2000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_LOW:    cfg.active_low    <= cfg_data[0];
        REG_SLOW_PERIOD:   cfg.slow_period   <= cfg_data;
        REG_FAST_PERIOD:   cfg.fast_period   <= cfg_data;
        REG_QUICK_PERIOD:  cfg.quick_period  <= cfg_data;
        REG_GROUP_PAUSE:   cfg.group_pause   <= cfg_data;
        REG_BEAT_INTERVAL: cfg.beat_interval <= cfg_data;
        REG_BEAT_DARK:     cfg.beat_dark     <= cfg_data;
        REG_REPAIR_PAUSE:  cfg.repair_pause  <= cfg_data;
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req.cmd         <= cmd;
      req.pattern_sel <= pattern_sel;
      req.node_state  <= node_state;
    end
  end

  lbp_step u_step (
    .cfg          (cfg),
    .req          (req),
    .cur          (state),
    .repair_ticks (16'(REPAIR_BLINK_TICKS)),
    .nxt          (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pin_level   <= state_next.lit ^ cfg.active_low;
      led_lit     <= state_next.lit;
      pattern_now <= state_next.pattern;
    end
  end

endmodule
